>>> hdl/bfs_pkg.sv
package bfs_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = 1 << ADDR_W;

   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;
   localparam int MAP_RESET = 64;
   localparam int WR_IDX_W  = 6;
   localparam int PIX_W     = 16;
   localparam int CRD_W     = 18;
   localparam int FRAC_W    = 14;
   localparam int ONE_Q     = 1 << FRAC_W;

   localparam int SIZE_W     = $clog2(MAX_DIM + 1);
   localparam int MUL_W      = CRD_W + SIZE_W + 2;
   localparam int POS_W      = MUL_W - FRAC_W;
   localparam int WGT_W      = FRAC_W + 1;
   localparam int P1_W       = PIX_W + WGT_W + 1;
   localparam int P2_W       = P1_W + WGT_W + 1;
   localparam int ACC_W      = P2_W;
   localparam int Q_W        = ACC_W - 2 * FRAC_W;
   localparam int ROUND_HALF = 1 << (2 * FRAC_W - 1);
   localparam int TAP_W      = 2;

   localparam logic [CSR_IDX_W-1:0] REG_MAP_HEIGHT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MAP_WIDTH  = CSR_IDX_W'(1);

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic [TAP_W-1:0] TAP_LAST = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } bfs_state_type;

   typedef struct packed {
      logic              in_map;
      logic [ADDR_W-1:0] addr;
      logic [WGT_W-1:0]  wr;
      logic [WGT_W-1:0]  wc;
   } bfs_tap_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v, input int maxv);
      if (v == '0) begin
         return SIZE_W'(1);
      end else if (int'(v) > maxv) begin
         return SIZE_W'(maxv);
      end else begin
         return SIZE_W'(v);
      end
   endfunction

endpackage

>>> hdl/bfs_if.sv
interface bfs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  req_type;
   logic [bfs_pkg::WR_IDX_W-1:0]          write_row;
   logic [bfs_pkg::WR_IDX_W-1:0]          write_col;
   logic signed [bfs_pkg::PIX_W-1:0]      pixel_value;
   logic signed [bfs_pkg::CRD_W-1:0]      coord_row;
   logic signed [bfs_pkg::CRD_W-1:0]      coord_col;

   modport source (
      output valid, req_type, write_row, write_col, pixel_value, coord_row, coord_col,
      input  ready
   );
   modport sink (
      input  valid, req_type, write_row, write_col, pixel_value, coord_row, coord_col,
      output ready
   );
endinterface

interface bfs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [bfs_pkg::PIX_W-1:0] sample_value;

   modport source (output valid, sample_value, input ready);
   modport sink (input valid, sample_value, output ready);
endinterface

interface bfs_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bfs_pkg::CSR_IDX_W-1:0]     index;
   logic [bfs_pkg::CFG_W-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/bfs_store.sv
module bfs_store (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [bfs_pkg::ADDR_W-1:0]       wr_addr,
   input  logic signed [bfs_pkg::PIX_W-1:0] wr_data,
   input  logic                             rd_en,
   input  logic [bfs_pkg::ADDR_W-1:0]       rd_addr,
   output logic signed [bfs_pkg::PIX_W-1:0] rd_data
);

   logic signed [bfs_pkg::PIX_W-1:0] store_mem [bfs_pkg::DEPTH];
   logic signed [bfs_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bfs_map.sv
module bfs_map (
   input  logic                              clock,
   input  logic                              start,
   input  logic signed [bfs_pkg::CRD_W-1:0]  coord_row,
   input  logic signed [bfs_pkg::CRD_W-1:0]  coord_col,
   input  logic [bfs_pkg::SIZE_W-1:0]        height,
   input  logic [bfs_pkg::SIZE_W-1:0]        width,
   input  logic [bfs_pkg::TAP_W-1:0]         tap_sel,
   output bfs_pkg::bfs_tap_type              tap
);

   logic signed [bfs_pkg::CRD_W:0]     row_ofs;
   logic signed [bfs_pkg::CRD_W:0]     col_ofs;
   logic signed [bfs_pkg::MUL_W-1:0]   row_mul;
   logic signed [bfs_pkg::MUL_W-1:0]   col_mul;
   logic signed [bfs_pkg::MUL_W-1:0]   xq_in;
   logic signed [bfs_pkg::MUL_W-1:0]   yq_in;
   logic signed [bfs_pkg::MUL_W-1:0]   xq_ff;
   logic signed [bfs_pkg::MUL_W-1:0]   yq_ff;
   logic [bfs_pkg::POS_W-1:0]          m;
   logic [bfs_pkg::POS_W-1:0]          n;
   logic [bfs_pkg::FRAC_W-1:0]         fx;
   logic [bfs_pkg::FRAC_W-1:0]         fy;
   logic [bfs_pkg::POS_W:0]            r;
   logic [bfs_pkg::POS_W:0]            c;
   logic                               row_ok;
   logic                               col_ok;

   assign row_ofs = $signed({coord_row[bfs_pkg::CRD_W-1], coord_row})
                  + $signed((bfs_pkg::CRD_W+1)'(bfs_pkg::ONE_Q));
   assign col_ofs = $signed({coord_col[bfs_pkg::CRD_W-1], coord_col})
                  + $signed((bfs_pkg::CRD_W+1)'(bfs_pkg::ONE_Q));
   assign row_mul = row_ofs * $signed({1'b0, height});
   assign col_mul = col_ofs * $signed({1'b0, width});
   assign xq_in   = row_mul >>> 1;
   assign yq_in   = col_mul >>> 1;

   always_ff @(posedge clock) begin
      if (start) begin
         xq_ff <= xq_in;
         yq_ff <= yq_in;
      end
   end

   assign m  = xq_ff[bfs_pkg::MUL_W-1:bfs_pkg::FRAC_W];
   assign n  = yq_ff[bfs_pkg::MUL_W-1:bfs_pkg::FRAC_W];
   assign fx = xq_ff[bfs_pkg::FRAC_W-1:0];
   assign fy = yq_ff[bfs_pkg::FRAC_W-1:0];

   assign r = {m[bfs_pkg::POS_W-1], m} + (bfs_pkg::POS_W+1)'(tap_sel[1]);
   assign c = {n[bfs_pkg::POS_W-1], n} + (bfs_pkg::POS_W+1)'(tap_sel[0]);

   assign row_ok = !r[bfs_pkg::POS_W]
                && (r[bfs_pkg::POS_W-1:0] < bfs_pkg::POS_W'(height));
   assign col_ok = !c[bfs_pkg::POS_W]
                && (c[bfs_pkg::POS_W-1:0] < bfs_pkg::POS_W'(width));

   always_comb begin
      tap.in_map = row_ok && col_ok;
      tap.addr   = {r[bfs_pkg::ROW_W-1:0], c[bfs_pkg::COL_W-1:0]};
      tap.wr     = tap_sel[1] ? {1'b0, fx}
                              : bfs_pkg::WGT_W'(bfs_pkg::ONE_Q) - {1'b0, fx};
      tap.wc     = tap_sel[0] ? {1'b0, fy}
                              : bfs_pkg::WGT_W'(bfs_pkg::ONE_Q) - {1'b0, fy};
   end

endmodule

>>> hdl/bfs_mac.sv
module bfs_mac (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  logic                             issue,
   input  bfs_pkg::bfs_tap_type             tap,
   input  logic signed [bfs_pkg::PIX_W-1:0] rd_data,
   output logic                             busy,
   output logic signed [bfs_pkg::PIX_W-1:0] result
);

   logic                              v1_ff;
   logic                              v2_ff;
   logic                              v3_ff;
   logic                              in_map1_ff;
   logic [bfs_pkg::WGT_W-1:0]         wr1_ff;
   logic [bfs_pkg::WGT_W-1:0]         wc1_ff;
   logic [bfs_pkg::WGT_W-1:0]         wc2_ff;
   logic signed [bfs_pkg::PIX_W-1:0]  pix;
   logic signed [bfs_pkg::P1_W-1:0]   p1_in;
   logic signed [bfs_pkg::P1_W-1:0]   p1_ff;
   logic signed [bfs_pkg::P2_W-1:0]   p2_in;
   logic signed [bfs_pkg::P2_W-1:0]   p2_ff;
   logic signed [bfs_pkg::ACC_W-1:0]  acc_in;
   logic signed [bfs_pkg::ACC_W-1:0]  acc_ff;
   logic [bfs_pkg::ACC_W-1:0]         rnd;
   logic [bfs_pkg::Q_W-1:0]           q;

   assign pix   = in_map1_ff ? rd_data : '0;
   assign p1_in = pix * $signed({1'b0, wr1_ff});
   assign p2_in = p1_ff * $signed({1'b0, wc2_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_map1_ff <= tap.in_map;
      wr1_ff     <= tap.wr;
      wc1_ff     <= tap.wc;
      wc2_ff     <= wc1_ff;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      acc_ff     <= acc_in;
   end

   always_comb begin
      if (clear) begin
         acc_in = '0;
      end else if (v3_ff) begin
         acc_in = acc_ff + p2_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   assign busy = v1_ff || v2_ff || v3_ff;

   assign rnd = acc_ff + bfs_pkg::ACC_W'(bfs_pkg::ROUND_HALF);
   assign q   = rnd[bfs_pkg::ACC_W-1:2*bfs_pkg::FRAC_W];

   always_comb begin
      if (!q[bfs_pkg::Q_W-1] && (|q[bfs_pkg::Q_W-2:bfs_pkg::PIX_W-1])) begin
         result = {1'b0, {(bfs_pkg::PIX_W-1){1'b1}}};
      end else if (q[bfs_pkg::Q_W-1] && !(&q[bfs_pkg::Q_W-2:bfs_pkg::PIX_W-1])) begin
         result = {1'b1, {(bfs_pkg::PIX_W-1){1'b0}}};
      end else begin
         result = q[bfs_pkg::PIX_W-1:0];
      end
   end

endmodule

>>> hdl/bilinear_feature_sampler.sv
// Bilinear sampler over one feature-map channel held in a 64x64 pixel store. A write
// transaction stores one pixel; a sample transaction maps its signed Q3.14 coordinates
// onto the map set by map_height/map_width, reads the four neighbours one after another
// through the single read port of the store, weights them bilinearly (neighbours off the
// map count as zero) and rounds to a 16-bit pixel. A sample occupies the block while it
// is accepted, reads the store, drains the multiply-accumulate pipeline and loads the
// response register, longer while that register still holds a result the receiver has
// not taken. The response register lets the next transaction enter while a result still
// waits. Write every pixel a sample can touch before sampling it; configuration may
// change only while the block is idle.
module bilinear_feature_sampler (
   input  logic               clock,
   input  logic               reset,
   bfs_req_if.sink            req_if,
   bfs_rsp_if.source          rsp_if,
   bfs_csr_if.sink            csr_if
);

   logic [bfs_pkg::CFG_W-1:0]          height_ff;
   logic [bfs_pkg::CFG_W-1:0]          width_ff;
   logic [bfs_pkg::SIZE_W-1:0]         height_eff;
   logic [bfs_pkg::SIZE_W-1:0]         width_eff;
   bfs_pkg::bfs_state_type             state_ff;
   bfs_pkg::bfs_state_type             state_in;
   logic [bfs_pkg::TAP_W-1:0]          k_ff;
   logic [bfs_pkg::TAP_W-1:0]          k_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic signed [bfs_pkg::PIX_W-1:0]   rsp_value_ff;
   logic                               req_acc;
   logic                               sample_acc;
   logic                               write_ok;
   logic                               issue;
   logic                               done_load;
   logic                               mac_busy;
   logic signed [bfs_pkg::PIX_W-1:0]   mac_result;
   logic signed [bfs_pkg::PIX_W-1:0]   rd_data;
   bfs_pkg::bfs_tap_type               tap;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= bfs_pkg::CFG_W'(bfs_pkg::MAP_RESET);
         width_ff  <= bfs_pkg::CFG_W'(bfs_pkg::MAP_RESET);
      end else if (csr_if.valid) begin
         if (csr_if.index == bfs_pkg::REG_MAP_HEIGHT) begin
            height_ff <= csr_if.data;
         end
         if (csr_if.index == bfs_pkg::REG_MAP_WIDTH) begin
            width_ff <= csr_if.data;
         end
      end
   end

   assign height_eff = bfs_pkg::clamp_size(height_ff, bfs_pkg::MAX_ROWS);
   assign width_eff  = bfs_pkg::clamp_size(width_ff, bfs_pkg::MAX_COLS);

   assign req_acc    = req_if.valid && req_if.ready;
   assign sample_acc = req_acc && (req_if.req_type == bfs_pkg::REQ_SAMPLE);
   assign write_ok   = req_acc && (req_if.req_type == bfs_pkg::REQ_WRITE)
                    && (32'(req_if.write_row) < bfs_pkg::MAX_ROWS)
                    && (32'(req_if.write_col) < bfs_pkg::MAX_COLS);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfs_pkg::ST_IDLE: begin
            if (sample_acc) begin
               state_in = bfs_pkg::ST_READ;
            end
         end
         bfs_pkg::ST_READ: begin
            if (k_ff == bfs_pkg::TAP_LAST) begin
               state_in = bfs_pkg::ST_DRAIN;
            end
         end
         bfs_pkg::ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = bfs_pkg::ST_DONE;
            end
         end
         bfs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               state_in = bfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_if.ready = 1'b0;
      issue        = 1'b0;
      done_load    = 1'b0;
      unique case (state_ff)
         bfs_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         bfs_pkg::ST_READ: begin
            issue = 1'b1;
         end
         bfs_pkg::ST_DRAIN: begin
         end
         bfs_pkg::ST_DONE: begin
            done_load = !rsp_valid_ff || rsp_if.ready;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (sample_acc) begin
         k_in = '0;
      end else if (issue) begin
         k_in = k_ff + bfs_pkg::TAP_W'(1);
      end else begin
         k_in = k_ff;
      end
   end

   always_comb begin
      if (done_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfs_pkg::ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_load) begin
         rsp_value_ff <= mac_result;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sample_value = rsp_value_ff;

   bfs_map u_map (
      .clock     (clock),
      .start     (sample_acc),
      .coord_row (req_if.coord_row),
      .coord_col (req_if.coord_col),
      .height    (height_eff),
      .width     (width_eff),
      .tap_sel   (k_ff),
      .tap       (tap)
   );

   bfs_store u_store (
      .clock   (clock),
      .wr_en   (write_ok),
      .wr_addr ({bfs_pkg::ROW_W'(req_if.write_row), bfs_pkg::COL_W'(req_if.write_col)}),
      .wr_data (req_if.pixel_value),
      .rd_en   (issue),
      .rd_addr (tap.addr),
      .rd_data (rd_data)
   );

   bfs_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .clear   (sample_acc),
      .issue   (issue),
      .tap     (tap),
      .rd_data (rd_data),
      .busy    (mac_busy),
      .result  (mac_result)
   );

endmodule

>>> sim/bilinear_sample_check.sv
module bilinear_sample_check
   import bfs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bfs_req_if   req_mon,
   bfs_rsp_if   rsp_mon,
   bfs_csr_if   csr_mon,
   output int   pending,
   output int   fail_count
);

   localparam longint PIX_HI = (longint'(1) <<< (PIX_W - 1)) - 1;
   localparam longint PIX_LO = -(longint'(1) <<< (PIX_W - 1));

   logic signed [PIX_W-1:0] pixel_mem [DEPTH];
   logic [CFG_W-1:0]        height_reg;
   logic [CFG_W-1:0]        width_reg;
   logic signed [PIX_W-1:0] samples_q [$];
   logic signed [PIX_W-1:0] oldest;

   function automatic longint dim_in_use(logic [CFG_W-1:0] raw, int limit);
      if (raw == '0) begin
         return 1;
      end
      if (int'(raw) > limit) begin
         return limit;
      end
      return longint'(raw);
   endfunction

   function automatic logic signed [PIX_W-1:0] bilinear_pixel(
      logic signed [CRD_W-1:0] crd_row,
      logic signed [CRD_W-1:0] crd_col
   );
      longint rows, cols, xq, yq, m, n, fx, fy, acc, r, c, q;
      longint wgt_r [2];
      longint wgt_c [2];
      rows = dim_in_use(height_reg, MAX_ROWS);
      cols = dim_in_use(width_reg, MAX_COLS);
      xq = ((longint'(crd_row) + ONE_Q) * rows) >>> 1;
      yq = ((longint'(crd_col) + ONE_Q) * cols) >>> 1;
      m = xq >>> FRAC_W;
      n = yq >>> FRAC_W;
      fx = xq - (m <<< FRAC_W);
      fy = yq - (n <<< FRAC_W);
      wgt_r[0] = ONE_Q - fx;
      wgt_r[1] = fx;
      wgt_c[0] = ONE_Q - fy;
      wgt_c[1] = fy;
      acc = 0;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            r = m + i;
            c = n + j;
            if (r >= 0 && r < rows && c >= 0 && c < cols) begin
               acc += wgt_r[i] * wgt_c[j] * longint'(pixel_mem[r * MAX_COLS + c]);
            end
         end
      end
      q = (acc + ROUND_HALF) >>> (2 * FRAC_W);
      if (q > PIX_HI) begin
         q = PIX_HI;
      end
      if (q < PIX_LO) begin
         q = PIX_LO;
      end
      return PIX_W'(q);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         height_reg = CFG_W'(MAP_RESET);
         width_reg  = CFG_W'(MAP_RESET);
         samples_q.delete();
         pending    <= 0;
         fail_count <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_MAP_HEIGHT: height_reg = csr_mon.data;
               REG_MAP_WIDTH:  width_reg  = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.req_type == REQ_WRITE) begin
               pixel_mem[int'(req_mon.write_row) * MAX_COLS + int'(req_mon.write_col)] =
                  req_mon.pixel_value;
            end else begin
               samples_q.push_back(bilinear_pixel(req_mon.coord_row, req_mon.coord_col));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (samples_q.size() == 0) begin
               $error("sample_value: unexpected transaction, expected none, actual %0d",
                      rsp_mon.sample_value);
               fail_count <= fail_count + 1;
            end else begin
               oldest = samples_q.pop_front();
               if (rsp_mon.sample_value !== oldest) begin
                  $error("sample_value: expected %0d, actual %0d", oldest,
                         rsp_mon.sample_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= samples_q.size();
      end
   end

endmodule

>>> sim/tb_top.sv
module tb_top;
   import bfs_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = CSR_IDX_W'(3);

   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 240;
   localparam int ITEM_TOTAL    = PHASES * PHASE_ITEMS;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_LIMIT   = 20000;

   logic clock = 1'b0;
   logic reset;
   logic rsp_take = 1'b0;
   int   pending;
   int   fail_count;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   items_sent;
   int   map_rows;
   int   map_cols;
   bit   hold_go = 1'b0;
   bit   hold_off = 1'b0;
   bit   pix_written [DEPTH];

   bfs_req_if req_ch ();
   bfs_rsp_if rsp_ch ();
   bfs_csr_if csr_ch ();

   assign rsp_ch.ready = rsp_take;

   bilinear_feature_sampler dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   bilinear_sample_check u_sample_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always #4 clock = ~clock;

   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_take <= 1'b0;
      end else begin
         rsp_take <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // hold off the receiver while the sender keeps offering
   initial begin
      do @(posedge clock); while (!hold_go);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   function automatic int dim_in_use(logic [CFG_W-1:0] raw, int limit);
      if (raw == '0) begin
         return 1;
      end
      if (int'(raw) > limit) begin
         return limit;
      end
      return int'(raw);
   endfunction

   function automatic longint map_origin(logic signed [CRD_W-1:0] crd, int size);
      return ((longint'(crd) + ONE_Q) * size) >>> (FRAC_W + 1);
   endfunction

   function automatic logic signed [CRD_W-1:0] random_coord();
      int sel;
      int v;
      sel = $urandom_range(99);
      if (sel < 55) begin
         v = int'($urandom_range(2 * ONE_Q - 1)) - ONE_Q;
      end else if (sel < 70) begin
         v = int'($urandom_range(40960)) - 20480;
      end else if (sel < 80) begin
         v = int'($urandom);
      end else begin
         v = (int'($urandom_range(2 * ONE_Q - 1)) & ~32'h3FF) - ONE_Q;
      end
      return CRD_W'(v);
   endfunction

   task automatic send_item(
      input logic                    kind,
      input logic [WR_IDX_W-1:0]     row,
      input logic [WR_IDX_W-1:0]     col,
      input logic signed [PIX_W-1:0] value,
      input logic signed [CRD_W-1:0] crd_row,
      input logic signed [CRD_W-1:0] crd_col
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= kind;
      req_ch.write_row   <= row;
      req_ch.write_col   <= col;
      req_ch.pixel_value <= value;
      req_ch.coord_row   <= crd_row;
      req_ch.coord_col   <= crd_col;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
   endtask

   task automatic send_write(int row, int col, logic signed [PIX_W-1:0] value);
      pix_written[row * MAX_COLS + col] = 1'b1;
      send_item(REQ_WRITE, WR_IDX_W'(row), WR_IDX_W'(col), value,
                CRD_W'($urandom), CRD_W'($urandom));
   endtask

   // fill any unwritten neighbour on the map before sampling
   task automatic send_sample(logic signed [CRD_W-1:0] crd_row, logic signed [CRD_W-1:0] crd_col);
      longint m, n, r, c;
      m = map_origin(crd_row, map_rows);
      n = map_origin(crd_col, map_cols);
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            r = m + i;
            c = n + j;
            if (r >= 0 && r < map_rows && c >= 0 && c < map_cols &&
                !pix_written[r * MAX_COLS + c]) begin
               send_write(int'(r), int'(c), PIX_W'($urandom));
            end
         end
      end
      send_item(REQ_SAMPLE, WR_IDX_W'($urandom), WR_IDX_W'($urandom), PIX_W'($urandom),
                crd_row, crd_col);
   endtask

   task automatic settle_block();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_map(logic [CFG_W-1:0] height_raw, logic [CFG_W-1:0] width_raw);
      logic [CSR_IDX_W-1:0] idx [3];
      logic [CFG_W-1:0]     val [3];
      idx[0] = REG_MAP_HEIGHT;
      val[0] = height_raw;
      idx[1] = $urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO;
      val[1] = CFG_W'($urandom);
      idx[2] = REG_MAP_WIDTH;
      val[2] = width_raw;
      for (int k = 0; k < 3; k++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[k];
         csr_ch.data  <= val[k];
         do @(posedge clock); while (csr_ch.ready !== 1'b1);
      end
      csr_ch.valid <= 1'b0;
      map_rows = dim_in_use(height_raw, MAX_ROWS);
      map_cols = dim_in_use(width_raw, MAX_COLS);
   endtask

   task automatic random_action();
      if (items_sent < ITEM_TOTAL / 3) begin
         send_idle_pct = 30;
         recv_idle_pct <= 70;
      end else if (items_sent < 2 * ITEM_TOTAL / 3) begin
         send_idle_pct = 70;
         recv_idle_pct <= 30;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct <= 0;
      end
      if (items_sent >= HOLD_AT) begin
         hold_go <= 1'b1;
      end
      if ($urandom_range(99) < 30) begin
         if ($urandom_range(1)) begin
            send_write($urandom_range(map_rows - 1), $urandom_range(map_cols - 1),
                       PIX_W'($urandom));
         end else begin
            send_write($urandom_range(MAX_ROWS - 1), $urandom_range(MAX_COLS - 1),
                       PIX_W'($urandom));
         end
      end else begin
         send_sample(random_coord(), random_coord());
      end
   endtask

   initial begin
      logic [CFG_W-1:0] phase_height [PHASES];
      logic [CFG_W-1:0] phase_width [PHASES];
      int target;
      phase_height = '{7'd1, 7'd0, 7'd64, 7'd2, 7'd5, 7'd0, 7'd0, 7'd64};
      phase_width  = '{7'd1, 7'd127, 7'd1, 7'd64, 7'd3, 7'd0, 7'd0, 7'd64};
      phase_height[5] = CFG_W'($urandom_range(64, 1));
      phase_width[5]  = CFG_W'($urandom_range(64, 1));
      phase_height[6] = CFG_W'($urandom_range(127, 65));
      phase_width[6]  = CFG_W'($urandom_range(64, 0));

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= REQ_WRITE;
      req_ch.write_row   <= '0;
      req_ch.write_col   <= '0;
      req_ch.pixel_value <= '0;
      req_ch.coord_row   <= '0;
      req_ch.coord_col   <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= REG_MAP_HEIGHT;
      csr_ch.data        <= '0;
      recv_idle_pct      <= 70;
      send_idle_pct = 30;
      map_rows      = MAP_RESET;
      map_cols      = MAP_RESET;
      items_sent    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // round half up, then a tie on the negative side
      send_write(0, 0, 1);
      send_write(1, 0, 0);
      send_write(0, 1, 0);
      send_write(1, 1, 0);
      send_sample(-16128, -16384);
      send_write(0, 0, -1);
      send_sample(-16128, -16384);
      // full-scale positive and negative neighbourhoods
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            send_write(62 + i, 62 + j, 32767);
         end
      end
      send_sample(15616, 15616);
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            send_write(62 + i, 62 + j, -32768);
         end
      end
      send_sample(15616, 15616);
      // far outside, map edges and center
      send_sample(131071, 131071);
      send_sample(-131072, -131072);
      send_sample(16383, 16383);
      send_sample(-16384, 16383);
      send_sample(0, 0);

      for (int p = 0; p < PHASES; p++) begin
         settle_block();
         program_map(phase_height[p], phase_width[p]);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            random_action();
         end
      end
      settle_block();

      if (pending != 0) begin
         $error("sample_value: %0d expected transactions never arrived", pending);
      end
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
